>>> rtl/core/sktt_pkg.sv
// shared types and constants for the sorted key counter with top-three ranking
package sktt_pkg;

	localparam int KEY_W    = 64;
	localparam int HIT_W    = 32;
	localparam int TOTAL_W  = 11;
	localparam int IDX_W    = 10;
	localparam int RANKED_N = 3;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_HIT   = 2'd1,
		FUNC_QUERY = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_MISSING = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SEARCH,
		ST_UPDATE,
		ST_RANK,
		ST_INSERT,
		ST_DONE
	} state_t;

	typedef struct packed {
		func_t              func;
		logic [KEY_W-1:0]   key;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               found;
		logic [HIT_W-1:0]   hit_count;
		logic [TOTAL_W-1:0] entry_total;
		logic [1:0]         ranked_filled;
		logic [IDX_W-1:0]   first_index;
		logic [IDX_W-1:0]   second_index;
		logic [IDX_W-1:0]   third_index;
	} rsp_t;

	typedef struct packed {
		logic take_in;
		logic do_load;
		logic search_start;
		logic search_step;
		logic do_update;
		logic rank_step;
		logic do_insert;
		logic set_result;
	} ctrl_cmd_t;

	typedef struct packed {
		func_t func;
		logic  empty;
		logic  key_eq;
		logic  more;
		logic  member;
		logic  member_first;
		logic  rank_last;
		logic  ranked_full;
	} dp_stat_t;

endpackage

>>> rtl/core/sktt_if.sv
// request and response stream interfaces
interface sktt_req_if;
	import sktt_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sktt_rsp_if;
	import sktt_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/sktt_ctrl.sv
// sequencer that steps one word through load, search, update and ranking
module sktt_ctrl import sktt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output ctrl_cmd_t cmd,
	input  dp_stat_t  stat
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.set_result) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take_in = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.func)
					FUNC_LOAD: begin
						cmd.do_load = 1'b1;
						state_d     = ST_DONE;
					end
					FUNC_HIT, FUNC_QUERY: begin
						cmd.search_start = 1'b1;
						state_d          = stat.empty ? ST_DONE : ST_SEARCH;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (stat.key_eq) begin
					state_d = (stat.func == FUNC_HIT) ? ST_UPDATE : ST_DONE;
				end else if (!stat.more) begin
					state_d = ST_DONE;
				end
			end
			ST_UPDATE: begin
				cmd.do_update = 1'b1;
				if (stat.member) begin
					state_d = stat.member_first ? ST_DONE : ST_RANK;
				end else begin
					state_d = stat.ranked_full ? ST_INSERT : ST_DONE;
				end
			end
			ST_RANK: begin
				cmd.rank_step = 1'b1;
				if (stat.rank_last) begin
					state_d = ST_DONE;
				end
			end
			ST_INSERT: begin
				cmd.do_insert = 1'b1;
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.set_result = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

>>> rtl/core/sktt_dp.sv
// key and count memories, search bounds, ranked slots and result register
module sktt_dp import sktt_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int COUNT_BITS  = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	input  req_t      req_data,
	output rsp_t      rsp_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int TW = $clog2(TABLE_DEPTH + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [KEY_W-1:0]      key_mem [TABLE_DEPTH];
	logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];
	logic [KEY_W-1:0]      key_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;

	func_t                 func_q;
	logic [KEY_W-1:0]      key_q;
	status_t               status_q;
	logic                  found_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [TW-1:0]         lo_q;
	logic [TW-1:0]         hi_q;
	logic [TW-1:0]         mid_q;
	logic [AW-1:0]         pos_q;
	logic [1:0]            j_q;
	logic [TW-1:0]         total_q;
	logic [1:0]            used_q;
	logic [AW-1:0]         slot_q [RANKED_N];
	logic [COUNT_BITS-1:0] shadow_q [RANKED_N];
	rsp_t                  rsp_q;

	logic                  full;
	logic                  key_lt;
	logic                  key_eq;
	logic [TW-1:0]         lo_n;
	logic [TW-1:0]         hi_n;
	logic [TW-1:0]         mid_n;
	logic [TW-1:0]         mid0;
	logic                  more;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [RANKED_N-1:0]   match;
	logic [1:0]            member_idx;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [63:0]           cnt_w;
	logic [31:0]           total_w;
	logic [31:0]           slot0_w;
	logic [31:0]           slot1_w;
	logic [31:0]           slot2_w;

	always_comb begin
		full    = (total_q >= TW'(TABLE_DEPTH));
		key_lt  = (key_rd_q < key_q);
		key_eq  = (key_rd_q == key_q);
		lo_n    = key_lt ? (mid_q + TW'(1)) : lo_q;
		hi_n    = key_lt ? hi_q : mid_q;
		mid_n   = lo_n + ((hi_n - lo_n - TW'(1)) >> 1);
		more    = (lo_n < hi_n);
		mid0    = (total_q - TW'(1)) >> 1;
		rd_en   = (cmd.search_start && (total_q != '0)) ||
		          (cmd.search_step && !key_eq && more);
		rd_addr = cmd.search_start ? mid0[AW-1:0] : mid_n[AW-1:0];
		new_cnt = (cnt_q == CNT_MAX) ? cnt_q : (cnt_q + COUNT_BITS'(1));
		for (int i = 0; i < RANKED_N; i++) begin
			match[i] = (used_q > 2'(i)) && (slot_q[i] == pos_q);
		end
		member_idx = match[2] ? 2'd2 : (match[1] ? 2'd1 : 2'd0);
	end

	always_comb begin
		stat.func         = func_q;
		stat.empty        = (total_q == '0);
		stat.key_eq       = key_eq;
		stat.more         = more;
		stat.member       = |match;
		stat.member_first = match[0];
		stat.rank_last    = (j_q == 2'd1);
		stat.ranked_full  = (used_q == 2'd3);
	end

	// memories: one write port and one registered read port each
	always_ff @(posedge clk) begin
		if (cmd.do_load && !full) begin
			key_mem[total_q[AW-1:0]] <= key_q;
		end
		if (rd_en) begin
			key_rd_q <= key_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_load && !full) begin
			cnt_mem[total_q[AW-1:0]] <= '0;
		end else if (cmd.do_update) begin
			cnt_mem[pos_q] <= new_cnt;
		end
		if (rd_en) begin
			cnt_rd_q <= cnt_mem[rd_addr];
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			func_q   <= req_data.func;
			key_q    <= req_data.key;
			status_q <= STATUS_OK;
			found_q  <= 1'b0;
			cnt_q    <= '0;
		end
		if (cmd.do_load) begin
			if (full) begin
				status_q <= STATUS_FULL;
			end else begin
				found_q <= 1'b1;
			end
		end
		if (cmd.search_start) begin
			lo_q  <= '0;
			hi_q  <= total_q;
			mid_q <= mid0;
			if (total_q == '0) begin
				status_q <= STATUS_MISSING;
			end
		end
		if (cmd.search_step) begin
			if (key_eq) begin
				found_q <= 1'b1;
				pos_q   <= mid_q[AW-1:0];
				cnt_q   <= cnt_rd_q;
			end else begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
				if (!more) begin
					status_q <= STATUS_MISSING;
				end
			end
		end
		if (cmd.do_update) begin
			cnt_q <= new_cnt;
			j_q   <= member_idx;
		end
		if (cmd.rank_step) begin
			j_q <= j_q - 2'd1;
		end
		if (cmd.set_result) begin
			rsp_q.status        <= status_q;
			rsp_q.found         <= found_q;
			rsp_q.hit_count     <= cnt_w[HIT_W-1:0];
			rsp_q.entry_total   <= total_w[TOTAL_W-1:0];
			rsp_q.ranked_filled <= used_q;
			rsp_q.first_index   <= slot0_w[IDX_W-1:0];
			rsp_q.second_index  <= slot1_w[IDX_W-1:0];
			rsp_q.third_index   <= slot2_w[IDX_W-1:0];
		end
	end

	assign cnt_w   = 64'(cnt_q);
	assign total_w = 32'(total_q);
	assign slot0_w = 32'(slot_q[0]);
	assign slot1_w = 32'(slot_q[1]);
	assign slot2_w = 32'(slot_q[2]);

	// table fill and ranked list; shadow_q mirrors the counts of the ranked entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			used_q  <= '0;
			for (int i = 0; i < RANKED_N; i++) begin
				slot_q[i]   <= '0;
				shadow_q[i] <= '0;
			end
		end else begin
			if (cmd.do_load && !full) begin
				total_q <= total_q + TW'(1);
				if (used_q != 2'd3) begin
					slot_q[used_q]   <= total_q[AW-1:0];
					shadow_q[used_q] <= '0;
					used_q           <= used_q + 2'd1;
				end
			end
			if (cmd.do_update) begin
				for (int i = 0; i < RANKED_N; i++) begin
					if (match[i]) begin
						shadow_q[i] <= new_cnt;
					end
				end
			end
			if (cmd.rank_step) begin
				unique case (j_q)
					2'd2: begin
						if (shadow_q[2] > shadow_q[1]) begin
							slot_q[2]   <= slot_q[1];
							slot_q[1]   <= slot_q[2];
							shadow_q[2] <= shadow_q[1];
							shadow_q[1] <= shadow_q[2];
						end
					end
					default: begin
						if (shadow_q[1] > shadow_q[0]) begin
							slot_q[1]   <= slot_q[0];
							slot_q[0]   <= slot_q[1];
							shadow_q[1] <= shadow_q[0];
							shadow_q[0] <= shadow_q[1];
						end
					end
				endcase
			end
			if (cmd.do_insert) begin
				priority if (cnt_q > shadow_q[0]) begin
					slot_q[2]   <= slot_q[1];
					slot_q[1]   <= slot_q[0];
					slot_q[0]   <= pos_q;
					shadow_q[2] <= shadow_q[1];
					shadow_q[1] <= shadow_q[0];
					shadow_q[0] <= cnt_q;
				end else if (cnt_q > shadow_q[1]) begin
					slot_q[2]   <= slot_q[1];
					slot_q[1]   <= pos_q;
					shadow_q[2] <= shadow_q[1];
					shadow_q[1] <= cnt_q;
				end else if (cnt_q > shadow_q[2]) begin
					slot_q[2]   <= pos_q;
					shadow_q[2] <= cnt_q;
				end
			end
		end
	end

	assign rsp_data = rsp_q;

endmodule

>>> rtl/core/sorted_key_counter_top_three.sv
// Sorted key counter with a ranked top-three list. Keys are loaded one per word; the
// user must load them in ascending unsigned order, which the block itself does not
// enforce. A hit word binary-searches the table, bumps the saturating count and
// re-ranks, a query word returns the count. The block works on one word at a time.
// A hit or query makes at most clog2(entries + 1) search probes, 11 for a full table
// of 1024. The search loop does one probe per cycle on the key memory's registered
// read port. A finished result waits in the output register while the next word is
// accepted. No clearing pass runs after reset.
module sorted_key_counter_top_three import sktt_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int COUNT_BITS  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	sktt_req_if.sink     req,
	sktt_rsp_if.source   rsp
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	sktt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	sktt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req_data (req.data),
		.rsp_data (rsp.data)
	);

endmodule

>>> rtl/core/sktt_checker.sv
// port-level checks on the sorted key counter, bound to the top level
module sktt_checker import sktt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word dropped while stalled");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second word taken while one is in progress");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.found |-> rsp_data.status == STATUS_OK)
		else $error("found word carries an error status");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.found |-> rsp_data.hit_count == '0)
		else $error("count reported for an absent key");

endmodule

bind sorted_key_counter_top_three sktt_checker u_sktt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

>>> dv/sorted_key_counter_top_three_tb.sv
// self-checking testbench for the sorted key counter: predicts every result word and compares it
`timescale 1ns / 1ps

module sorted_key_counter_top_three_tb;
	import sktt_pkg::*;

	localparam int DEPTH = 1024;
	localparam int CNT_BITS = 32;
	localparam func_t FUNC_SPARE = func_t'(2'b11);
	localparam int IDLE_PCT = 36;
	localparam int RANDOM_WORDS = 1500;
	localparam int PAUSE_AT = 700;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 250;
	localparam int CALM_FROM = 6000;
	localparam int CALM_TO = 9000;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic snd_valid = 1'b0;
	req_t snd_word = '0;
	logic rcv_ready = 1'b0;

	sktt_req_if req_ch ();
	sktt_rsp_if rsp_ch ();

	assign req_ch.valid = snd_valid;
	assign req_ch.data = snd_word;
	assign rsp_ch.ready = rcv_ready;

	sorted_key_counter_top_three #(
		.TABLE_DEPTH(DEPTH),
		.COUNT_BITS(CNT_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// own copy of the counter state
	logic [KEY_W-1:0] key_tab [DEPTH];
	logic [HIT_W-1:0] hits_tab [DEPTH];
	int loaded_n = 0;
	logic [IDX_W-1:0] rank_idx [RANKED_N] = '{default: '0};
	int rank_n = 0;

	req_t word_q [$];
	rsp_t result_q [$];
	logic [KEY_W-1:0] gen_keys [$];

	logic word_taken = 1'b0;
	int cyc = 0;
	int rsp_seen = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int sent_n = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// same probe order as the hardware search: mid biased low on an even span
	function automatic bit locate(input logic [KEY_W-1:0] k, output int at);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = loaded_n;
		at = 0;
		while (lo < hi) begin
			mid = lo + (hi - lo - 1) / 2;
			if (key_tab[mid] == k) begin
				at = mid;
				return 1'b1;
			end
			if (key_tab[mid] < k) lo = mid + 1;
			else hi = mid;
		end
		return 1'b0;
	endfunction

	function automatic void rerank(input int x);
		logic [IDX_W-1:0] t;
		logic [HIT_W-1:0] c;
		for (int i = 0; i < rank_n; i++) begin
			if (rank_idx[i] == x) begin
				// bubble pass all the way up, no early stop
				for (int j = i; j > 0; j--) begin
					if (hits_tab[rank_idx[j]] > hits_tab[rank_idx[j-1]]) begin
						t = rank_idx[j];
						rank_idx[j] = rank_idx[j-1];
						rank_idx[j-1] = t;
					end
				end
				return;
			end
		end
		if (rank_n < RANKED_N) return;
		c = hits_tab[x];
		if (c > hits_tab[rank_idx[0]]) begin
			rank_idx[2] = rank_idx[1];
			rank_idx[1] = rank_idx[0];
			rank_idx[0] = IDX_W'(x);
		end else if (c > hits_tab[rank_idx[1]]) begin
			rank_idx[2] = rank_idx[1];
			rank_idx[1] = IDX_W'(x);
		end else if (c > hits_tab[rank_idx[2]]) begin
			rank_idx[2] = IDX_W'(x);
		end
	endfunction

	function automatic rsp_t counter_step(input req_t w);
		rsp_t r;
		int at;
		r = '0;
		r.status = STATUS_OK;
		if (w.func == FUNC_LOAD) begin
			if (loaded_n < DEPTH) begin
				key_tab[loaded_n] = w.key;
				hits_tab[loaded_n] = '0;
				if (rank_n < RANKED_N) begin
					rank_idx[rank_n] = IDX_W'(loaded_n);
					rank_n++;
				end
				loaded_n++;
				r.found = 1'b1;
			end else begin
				r.status = STATUS_FULL;
			end
		end else if (w.func == FUNC_HIT || w.func == FUNC_QUERY) begin
			if (locate(w.key, at)) begin
				r.found = 1'b1;
				if (w.func == FUNC_HIT) begin
					// saturating count, ranking re-run either way
					if (hits_tab[at] != '1) hits_tab[at] = hits_tab[at] + 1'b1;
					rerank(at);
				end
				r.hit_count = hits_tab[at];
			end else begin
				r.status = STATUS_MISSING;
			end
		end
		r.entry_total = TOTAL_W'(loaded_n);
		r.ranked_filled = 2'(rank_n);
		r.first_index = rank_idx[0];
		r.second_index = rank_idx[1];
		r.third_index = rank_idx[2];
		return r;
	endfunction

	function automatic void queue_word(input func_t f, input logic [KEY_W-1:0] k);
		req_t w;
		w.func = f;
		w.key = k;
		word_q.insert(word_q.size(), w);
		if (f == FUNC_LOAD && gen_keys.size() < DEPTH) gen_keys.insert(gen_keys.size(), k);
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n) begin
			cyc++;
			word_taken <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready)
				result_q.insert(result_q.size(), counter_step(req_ch.data));
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				rsp_seen++;
				if (result_q.size() == 0) begin
					$error("result word with no request outstanding");
					mismatches++;
				end else begin
					want = result_q.pop_front();
					if (got.status !== want.status) begin
						$error("status expected %0d got %0d", want.status, got.status);
						mismatches++;
					end
					if (got.found !== want.found) begin
						$error("found expected %0d got %0d", want.found, got.found);
						mismatches++;
					end
					if (got.hit_count !== want.hit_count) begin
						$error("hit_count expected %0d got %0d", want.hit_count, got.hit_count);
						mismatches++;
					end
					if (got.entry_total !== want.entry_total) begin
						$error("entry_total expected %0d got %0d", want.entry_total,
							got.entry_total);
						mismatches++;
					end
					if (got.ranked_filled !== want.ranked_filled) begin
						$error("ranked_filled expected %0d got %0d", want.ranked_filled,
							got.ranked_filled);
						mismatches++;
					end
					if (got.first_index !== want.first_index) begin
						$error("first_index expected %0d got %0d", want.first_index,
							got.first_index);
						mismatches++;
					end
					if (got.second_index !== want.second_index) begin
						$error("second_index expected %0d got %0d", want.second_index,
							got.second_index);
						mismatches++;
					end
					if (got.third_index !== want.third_index) begin
						$error("third_index expected %0d got %0d", want.third_index,
							got.third_index);
						mismatches++;
					end
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		logic calm;
		logic go;
		calm = cyc >= CALM_FROM && cyc < CALM_TO;
		if (arst_n && (!snd_valid || word_taken)) begin
			// one pause: hold the stream until every word sent so far is answered
			go = word_q.size() != 0 && !(sent_n == PAUSE_AT && result_q.size() != 0)
				&& (calm || $urandom_range(99) >= IDLE_PCT);
			if (go) begin
				snd_word <= word_q.pop_front();
				snd_valid <= 1'b1;
				sent_n++;
			end else begin
				snd_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && rsp_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rcv_ready <= 1'b0;
			end else begin
				rcv_ready <= (cyc >= CALM_FROM && cyc < CALM_TO) || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] next_key;
		logic [KEY_W-1:0] k;
		int hot_base;
		int idx;
		int pick;
		hot_base = 0;

		// empty table, unused code, duplicate key, insertion into a full ranking
		queue_word(FUNC_QUERY, '0);
		queue_word(FUNC_HIT, '1);
		queue_word(FUNC_SPARE, 64'h5555_5555_aaaa_aaaa);
		queue_word(FUNC_LOAD, '0);
		queue_word(FUNC_HIT, '0);
		queue_word(FUNC_LOAD, 64'h10);
		queue_word(FUNC_LOAD, 64'h10);
		queue_word(FUNC_LOAD, 64'h3000);
		queue_word(FUNC_HIT, 64'h3000);
		queue_word(FUNC_HIT, 64'h3000);
		queue_word(FUNC_HIT, 64'h10);
		queue_word(FUNC_HIT, 64'h10);
		queue_word(FUNC_QUERY, 64'h3000);
		queue_word(FUNC_QUERY, 64'h5);
		queue_word(FUNC_HIT, 64'h3001);
		queue_word(FUNC_QUERY, '1);
		queue_word(FUNC_SPARE, '0);
		next_key = 64'h3000;

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(99);
			// move the hot window now and then so new entries climb the ranking
			if (n % 150 == 0 && gen_keys.size() != 0)
				hot_base = $urandom_range(gen_keys.size() - 1);
			if (pick < 2) begin
				queue_word(FUNC_SPARE, {$urandom, $urandom});
			end else if (pick < (gen_keys.size() < DEPTH ? 77 : 17)) begin
				if (gen_keys.size() == DEPTH - 1) begin
					k = '1;
				end else if ($urandom_range(99) == 0) begin
					k = {$urandom, $urandom};
				end else begin
					next_key = next_key + 1 + {21'($urandom), $urandom};
					k = next_key;
				end
				queue_word(FUNC_LOAD, k);
			end else begin
				pick = $urandom_range(99);
				if (gen_keys.size() == 0 || pick < 10) begin
					k = {$urandom, $urandom};
				end else if (pick < 20) begin
					k = gen_keys[$urandom_range(gen_keys.size() - 1)] + 1;
				end else if (pick < 65) begin
					idx = hot_base + $urandom_range(3);
					if (idx >= gen_keys.size()) idx = gen_keys.size() - 1;
					k = gen_keys[idx];
				end else begin
					k = gen_keys[$urandom_range(gen_keys.size() - 1)];
				end
				queue_word($urandom_range(99) < 70 ? FUNC_HIT : FUNC_QUERY, k);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (word_q.size() != 0 || snd_valid) @(negedge clk);
		while (result_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
